/* hdl/npclip_pkg.sv */
// ----------------------------------------------------------------------------
// npclip_pkg
// Shared types and constants for the near-plane triangle clipper.
// ----------------------------------------------------------------------------
package npclip_pkg;

  // fixed-point 1.0 in Q16.16
  localparam logic signed [31:0] FIX_ONE = 32'sh0001_0000;

  // queue between classifier and clip engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register map
  localparam int PADDR_W = 4;
  localparam logic [PADDR_W-1:0] ADDR_CAMERA_X = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_CAMERA_Y = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_CAMERA_Z = 4'h8;

  // clip engine timing
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_OPS   = 4;
  localparam int MUL_CNT_W = $clog2(MUL_OPS + 1);

  typedef struct packed {
    logic signed [31:0] in_a_x;
    logic signed [31:0] in_a_y;
    logic signed [31:0] in_a_z;
    logic signed [31:0] in_b_x;
    logic signed [31:0] in_b_y;
    logic signed [31:0] in_b_z;
    logic signed [31:0] in_c_x;
    logic signed [31:0] in_c_y;
    logic signed [31:0] in_c_z;
    logic        [31:0] in_color;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_a_z;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic signed [31:0] out_b_z;
    logic signed [31:0] out_c_x;
    logic signed [31:0] out_c_y;
    logic signed [31:0] out_c_z;
    logic        [31:0] out_color;
    logic               out_last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  // classified triangle: pivot vertex and the two others in input order
  typedef struct packed {
    kind_t       kind;
    vtx_t        p;
    vtx_t        q1;
    vtx_t        q2;
    logic [31:0] color;
  } clip_rec_t;

  // queue handshake between modules
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT0,
    ST_EMIT1
  } back_state_t;

  // saturating a - b on 32-bit signed values
  function automatic logic signed [31:0] sub_sat(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sub_sat = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sub_sat = d[31:0];
    end
  endfunction

endpackage

/* hdl/near_plane_triangle_clipper.sv */
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper
// Near-plane clipper for Q16.16 triangles with a camera offset register set.
// ----------------------------------------------------------------------------
// A triangle with all vertices in front of z = 1 skips the dividers and the
// multiplier and comes out as one word. A triangle with one or two vertices
// behind goes through the clip engine: a load, the two bit-serial dividers
// that form the edge fractions, the shared 32x32 multiplier, then one output
// word (two vertices behind) or two (one behind). The engine takes no new
// triangle until it has emitted the last word of the current one. A
// two-entry queue lets the classifier take new words while the engine is
// busy; fully hidden triangles are dropped by the classifier.
module near_plane_triangle_clipper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  npclip_pkg::in_word_t              in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output npclip_pkg::out_word_t             out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npclip_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic signed [31:0]    camera_x, camera_y, camera_z;
  logic                  wr_en;
  logic                  push, pop;
  npclip_pkg::clip_rec_t push_data, pop_data;
  npclip_pkg::q_status_t q_status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // camera registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (wr_en) begin
      case (paddr)
        npclip_pkg::ADDR_CAMERA_X: camera_x <= pwdata;
        npclip_pkg::ADDR_CAMERA_Y: camera_y <= pwdata;
        npclip_pkg::ADDR_CAMERA_Z: camera_z <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr)
      npclip_pkg::ADDR_CAMERA_X: prdata = camera_x;
      npclip_pkg::ADDR_CAMERA_Y: prdata = camera_y;
      npclip_pkg::ADDR_CAMERA_Z: prdata = camera_z;
      default: prdata = '0;
    endcase
  end

  npclip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .camera_x  (camera_x),
    .camera_y  (camera_y),
    .camera_z  (camera_z),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  npclip_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  npclip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hdl/npclip_fifo.sv */
// ----------------------------------------------------------------------------
// npclip_fifo
// Short register queue of classified triangles between front and back.
// ----------------------------------------------------------------------------
module npclip_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  npclip_pkg::clip_rec_t push_data,
  input  logic                  pop,
  output npclip_pkg::clip_rec_t pop_data,
  output npclip_pkg::q_status_t status
);

  npclip_pkg::clip_rec_t           entry [npclip_pkg::QDEPTH];
  logic [npclip_pkg::QPTR_W-1:0]   wr_ptr;
  logic [npclip_pkg::QPTR_W-1:0]   rd_ptr;
  logic [npclip_pkg::QCNT_W-1:0]   count;

  assign status.full  = (count == npclip_pkg::QCNT_W'(npclip_pkg::QDEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entry[rd_ptr];

  // pointer wrap
  function automatic logic [npclip_pkg::QPTR_W-1:0] bump(
      logic [npclip_pkg::QPTR_W-1:0] p);
    if (p == npclip_pkg::QPTR_W'(npclip_pkg::QDEPTH - 1)) begin
      bump = '0;
    end else begin
      bump = p + 1'b1;
    end
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/npclip_front.sv */
// ----------------------------------------------------------------------------
// npclip_front
// Takes input words, moves them to camera space and classifies them
// by how many vertices lie behind the near plane.
// ----------------------------------------------------------------------------
module npclip_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  npclip_pkg::in_word_t  in_word,
  input  logic signed [31:0]    camera_x,
  input  logic signed [31:0]    camera_y,
  input  logic signed [31:0]    camera_z,
  input  npclip_pkg::q_status_t q_status,
  output logic                  push,
  output npclip_pkg::clip_rec_t push_data
);

  npclip_pkg::vtx_t      v [3];
  logic [2:0]            behind;
  npclip_pkg::clip_rec_t rec;
  logic                  hold_valid;
  npclip_pkg::clip_rec_t hold;
  logic                  take;

  // camera-relative vertices
  always_comb begin
    v[0].x = npclip_pkg::sub_sat(in_word.in_a_x, camera_x);
    v[0].y = npclip_pkg::sub_sat(in_word.in_a_y, camera_y);
    v[0].z = npclip_pkg::sub_sat(in_word.in_a_z, camera_z);
    v[1].x = npclip_pkg::sub_sat(in_word.in_b_x, camera_x);
    v[1].y = npclip_pkg::sub_sat(in_word.in_b_y, camera_y);
    v[1].z = npclip_pkg::sub_sat(in_word.in_b_z, camera_z);
    v[2].x = npclip_pkg::sub_sat(in_word.in_c_x, camera_x);
    v[2].y = npclip_pkg::sub_sat(in_word.in_c_y, camera_y);
    v[2].z = npclip_pkg::sub_sat(in_word.in_c_z, camera_z);
  end

  assign behind[0] = (v[0].z < npclip_pkg::FIX_ONE);
  assign behind[1] = (v[1].z < npclip_pkg::FIX_ONE);
  assign behind[2] = (v[2].z < npclip_pkg::FIX_ONE);

  // pick pivot: the lone vertex of its side, the others keep input order
  always_comb begin
    rec.color = in_word.in_color;
    rec.kind  = npclip_pkg::KIND_PASS;
    rec.p     = v[0];
    rec.q1    = v[1];
    rec.q2    = v[2];
    case (behind)
      3'b000: begin
        rec.kind = npclip_pkg::KIND_PASS;
      end
      3'b001, 3'b110: begin
        rec.kind = behind[0] ? npclip_pkg::KIND_ONE : npclip_pkg::KIND_TWO;
      end
      3'b010, 3'b101: begin
        rec.kind = behind[1] ? npclip_pkg::KIND_ONE : npclip_pkg::KIND_TWO;
        rec.p    = v[1];
        rec.q1   = v[0];
      end
      3'b100, 3'b011: begin
        rec.kind = behind[2] ? npclip_pkg::KIND_ONE : npclip_pkg::KIND_TWO;
        rec.p    = v[2];
        rec.q1   = v[0];
        rec.q2   = v[1];
      end
      default: begin
        rec.kind = npclip_pkg::KIND_PASS;
      end
    endcase
  end

  assign push      = hold_valid && !q_status.full;
  assign push_data = hold;
  assign in_stall  = hold_valid && q_status.full;
  assign take      = in_valid && !in_stall;

  // holding register; fully hidden triangles are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= (behind != 3'b111);
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= rec;
    end
  end

endmodule

/* hdl/npclip_back.sv */
// ----------------------------------------------------------------------------
// npclip_back
// Clip engine: two restoring dividers for the edge fractions, one shared
// 32x32 multiplier for the offsets, and the output register.
// ----------------------------------------------------------------------------
module npclip_back (
  input  logic                  clk,
  input  logic                  rst,
  input  npclip_pkg::q_status_t q_status,
  input  npclip_pkg::clip_rec_t pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output npclip_pkg::out_word_t out_word
);

  npclip_pkg::back_state_t          state;
  npclip_pkg::back_state_t          state_next;
  npclip_pkg::clip_rec_t            cur;
  logic [npclip_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [npclip_pkg::MUL_CNT_W-1:0] mul_cnt;

  // divider lanes
  logic [31:0] den1, den2;
  logic [31:0] rem1, rem2;
  logic [31:0] quo1, quo2;
  logic [31:0] dtail;
  logic [32:0] trial1, trial2;
  logic        ge1, ge2;

  // operands for the offset products
  logic [31:0] dxm1, dym1, dxm2, dym2;
  logic [3:0]  dneg;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;

  // clip point results
  logic signed [31:0] c1x, c1y, c2x, c2y;
  logic signed [31:0] base;
  logic               neg_sel;
  logic signed [33:0] sum;
  logic signed [31:0] sum_sat;

  logic                  out_free;
  logic                  out_load;
  npclip_pkg::out_word_t word;

  // load-time differences
  logic signed [32:0] num_s, dz1_s, dz2_s;
  logic signed [32:0] dx1_s, dy1_s, dx2_s, dy2_s;
  logic [31:0]        numm;

  function automatic logic [31:0] mag33(logic signed [32:0] a);
    logic signed [32:0] n;
    n = -a;
    mag33 = a[32] ? n[31:0] : a[31:0];
  endfunction

  function automatic logic signed [32:0] dif(logic signed [31:0] a,
                                             logic signed [31:0] b);
    dif = {a[31], a} - {b[31], b};
  endfunction

  assign num_s = dif(npclip_pkg::FIX_ONE, pop_data.p.z);
  assign dz1_s = dif(pop_data.q1.z, pop_data.p.z);
  assign dz2_s = dif(pop_data.q2.z, pop_data.p.z);
  assign dx1_s = dif(pop_data.q1.x, pop_data.p.x);
  assign dy1_s = dif(pop_data.q1.y, pop_data.p.y);
  assign dx2_s = dif(pop_data.q2.x, pop_data.p.x);
  assign dy2_s = dif(pop_data.q2.y, pop_data.p.y);
  assign numm  = mag33(num_s);

  assign out_free = !out_valid || !out_stall;

  // restoring division step
  assign trial1 = {rem1, dtail[31]};
  assign trial2 = {rem2, dtail[31]};
  assign ge1    = (trial1 >= {1'b0, den1});
  assign ge2    = (trial2 >= {1'b0, den2});

  // multiplier operand select, zero divisor gives a zero fraction
  always_comb begin
    case (mul_cnt)
      3'd0: begin mul_a = dxm1; mul_b = (den1 == '0) ? '0 : quo1; end
      3'd1: begin mul_a = dym1; mul_b = (den1 == '0) ? '0 : quo1; end
      3'd2: begin mul_a = dxm2; mul_b = (den2 == '0) ? '0 : quo2; end
      default: begin mul_a = dym2; mul_b = (den2 == '0) ? '0 : quo2; end
    endcase
  end

  // apply the previous product to the pivot
  always_comb begin
    case (mul_cnt)
      3'd1: begin base = cur.p.x; neg_sel = dneg[0]; end
      3'd2: begin base = cur.p.y; neg_sel = dneg[1]; end
      3'd3: begin base = cur.p.x; neg_sel = dneg[2]; end
      default: begin base = cur.p.y; neg_sel = dneg[3]; end
    endcase
    if (neg_sel) begin
      sum = {{2{base[31]}}, base} - {1'b0, prod[63:31]};
    end else begin
      sum = {{2{base[31]}}, base} + {1'b0, prod[63:31]};
    end
    if (sum > 34'sh0_7fff_ffff) begin
      sum_sat = 32'sh7fff_ffff;
    end else if (sum < -34'sh0_8000_0000) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      npclip_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = (pop_data.kind == npclip_pkg::KIND_PASS) ?
                       npclip_pkg::ST_EMIT0 : npclip_pkg::ST_DIV;
        end
      end
      npclip_pkg::ST_DIV: begin
        if (div_cnt == npclip_pkg::DIV_CNT_W'(npclip_pkg::DIV_STEPS - 1)) begin
          state_next = npclip_pkg::ST_MUL;
        end
      end
      npclip_pkg::ST_MUL: begin
        if (mul_cnt == npclip_pkg::MUL_CNT_W'(npclip_pkg::MUL_OPS)) begin
          state_next = npclip_pkg::ST_EMIT0;
        end
      end
      npclip_pkg::ST_EMIT0: begin
        if (out_free) begin
          state_next = (cur.kind == npclip_pkg::KIND_ONE) ?
                       npclip_pkg::ST_EMIT1 : npclip_pkg::ST_IDLE;
        end
      end
      npclip_pkg::ST_EMIT1: begin
        if (out_free) begin
          state_next = npclip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = npclip_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    word     = '0;
    word.out_color = cur.color;
    case (state)
      npclip_pkg::ST_IDLE: begin
        pop = !q_status.empty;
      end
      npclip_pkg::ST_EMIT0: begin
        out_load = out_free;
        case (cur.kind)
          npclip_pkg::KIND_ONE: begin
            word.out_a_x = c1x; word.out_a_y = c1y; word.out_a_z = npclip_pkg::FIX_ONE;
            word.out_b_x = cur.q1.x; word.out_b_y = cur.q1.y; word.out_b_z = cur.q1.z;
            word.out_c_x = cur.q2.x; word.out_c_y = cur.q2.y; word.out_c_z = cur.q2.z;
            word.out_last = 1'b0;
          end
          npclip_pkg::KIND_TWO: begin
            word.out_a_x = c1x; word.out_a_y = c1y; word.out_a_z = npclip_pkg::FIX_ONE;
            word.out_b_x = c2x; word.out_b_y = c2y; word.out_b_z = npclip_pkg::FIX_ONE;
            word.out_c_x = cur.p.x; word.out_c_y = cur.p.y; word.out_c_z = cur.p.z;
            word.out_last = 1'b1;
          end
          default: begin
            word.out_a_x = cur.p.x; word.out_a_y = cur.p.y; word.out_a_z = cur.p.z;
            word.out_b_x = cur.q1.x; word.out_b_y = cur.q1.y; word.out_b_z = cur.q1.z;
            word.out_c_x = cur.q2.x; word.out_c_y = cur.q2.y; word.out_c_z = cur.q2.z;
            word.out_last = 1'b1;
          end
        endcase
      end
      npclip_pkg::ST_EMIT1: begin
        out_load = out_free;
        word.out_a_x = c1x; word.out_a_y = c1y; word.out_a_z = npclip_pkg::FIX_ONE;
        word.out_b_x = c2x; word.out_b_y = c2y; word.out_b_z = npclip_pkg::FIX_ONE;
        word.out_c_x = cur.q2.x; word.out_c_y = cur.q2.y; word.out_c_z = cur.q2.z;
        word.out_last = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npclip_pkg::ST_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
      mul_cnt   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == npclip_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
      if (state == npclip_pkg::ST_MUL) begin
        mul_cnt <= mul_cnt + 1'b1;
      end else begin
        mul_cnt <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= pop_data;
      den1  <= mag33(dz1_s);
      den2  <= mag33(dz2_s);
      rem1  <= {1'b0, numm[31:1]};
      rem2  <= {1'b0, numm[31:1]};
      dtail <= {numm[0], 31'b0};
      dxm1  <= mag33(dx1_s);
      dym1  <= mag33(dy1_s);
      dxm2  <= mag33(dx2_s);
      dym2  <= mag33(dy2_s);
      dneg  <= {dy2_s[32], dx2_s[32], dy1_s[32], dx1_s[32]};
    end
    if (state == npclip_pkg::ST_DIV) begin
      rem1  <= ge1 ? 32'(trial1 - {1'b0, den1}) : trial1[31:0];
      rem2  <= ge2 ? 32'(trial2 - {1'b0, den2}) : trial2[31:0];
      quo1  <= {quo1[30:0], ge1};
      quo2  <= {quo2[30:0], ge2};
      dtail <= {dtail[30:0], 1'b0};
    end
    if (state == npclip_pkg::ST_MUL) begin
      if (mul_cnt < npclip_pkg::MUL_CNT_W'(npclip_pkg::MUL_OPS)) begin
        prod <= mul_a * mul_b;
      end
      case (mul_cnt)
        3'd1: c1x <= sum_sat;
        3'd2: c1y <= sum_sat;
        3'd3: c2x <= sum_sat;
        3'd4: c2y <= sum_sat;
        default: ;
      endcase
    end
    if (out_load) begin
      out_word <= word;
    end
  end

endmodule

/* hdl/npclip_checker.sv */
// ----------------------------------------------------------------------------
// npclip_sva
// Port-level checks for the near-plane triangle clipper.
// ----------------------------------------------------------------------------
module npclip_sva (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input npclip_pkg::out_word_t out_word,
  input logic                  pready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // only the first word of a split triangle is not last, and it starts at a clip point
  a_split_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.out_last |-> out_word.out_a_z == npclip_pkg::FIX_ONE)
    else $error("non-final word does not start at the near plane");

  // the word after a non-final word continues the same triangle
  a_split_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_word.out_last |=>
      out_word.out_a_z == npclip_pkg::FIX_ONE && out_word.out_b_z == npclip_pkg::FIX_ONE)
    else $error("second word of a split triangle is malformed");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind near_plane_triangle_clipper npclip_sva u_npclip_sva (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word),
  .pready    (pready)
);
